// ===== src/tpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch point matcher package
// Shared widths, codes, controller states and the command and status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tpm_pkg;

  // Width of every coordinate field on the ports.
  localparam int FIELD_W = 13;

  // Defaults for the top level parameters.
  localparam int MAX_TOUCH_DEF  = 16;
  localparam int COORD_BITS_DEF = 13;

  typedef enum logic [1:0] {
    OP_LOAD_PREV = 2'd0,
    OP_LOAD_NEW  = 2'd1,
    OP_MATCH     = 2'd2,
    OP_IGNORE    = 2'd3
  } tpm_op_e;

  typedef enum logic [1:0] {
    KIND_MOVE  = 2'd0,
    KIND_NEW   = 2'd1,
    KIND_ENDED = 2'd2,
    KIND_NONE  = 2'd3
  } tpm_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAIR,
    ST_LOADP,
    ST_ISSUE,
    ST_DRAIN,
    ST_MOVE,
    ST_NSCAN,
    ST_NEW,
    ST_ESCAN,
    ST_ENDED,
    ST_NONE,
    ST_DONE
  } tpm_state_e;

  typedef struct packed {
    logic      prev_we;
    logic      new_we;
    logic      prev_re;
    logic      new_re;
    logic      latch_prev;
    logic      clr_best;
    logic      issue;
    logic      out_load;
    tpm_kind_e out_kind;
    logic      out_last;
    logic      out_ovf;
  } tpm_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } tpm_sts_t;

endpackage

`default_nettype wire

// ===== src/tpm_req_if.sv =====
// ----------------------------------------------------------------------------
// Touch point matcher request channel
// Valid/ready channel carrying one operation and one point.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpm_req_if import tpm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [FIELD_W-1:0] point_x;
  logic [FIELD_W-1:0] point_y;

  modport source (output valid, operation, point_x, point_y, input ready);
  modport sink   (input valid, operation, point_x, point_y, output ready);
endinterface

`default_nettype wire

// ===== src/tpm_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Touch point matcher result channel
// Valid/ready channel carrying one matched, new, ended or empty result.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpm_rsp_if import tpm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [FIELD_W-1:0] from_x;
  logic [FIELD_W-1:0] from_y;
  logic [FIELD_W-1:0] to_x;
  logic [FIELD_W-1:0] to_y;
  logic               overflow;
  logic               last;

  modport source (output valid, kind, from_x, from_y, to_x, to_y, overflow, last,
                  input ready);
  modport sink   (input valid, kind, from_x, from_y, to_x, to_y, overflow, last,
                  output ready);
endinterface

`default_nettype wire

// ===== src/touch_point_matcher.sv =====
// ----------------------------------------------------------------------------
// Touch point matcher
// Pairs each previous touch point with its nearest unused new touch point.
// ----------------------------------------------------------------------------
// The request channel carries an operation and a point. A load-previous or
// load-new request appends the point to its store and gives no
// result; a load into a full store is dropped and remembered. A match request
// walks the previous points in load order and pairs each one with the nearest
// unused new point by squared distance, the lowest index winning a tie. The
// run then sends one movement per pair, each unpaired new point as a new
// touch, each unpaired previous point as an ended touch, and a single none
// result when both stores were empty. The last result of a run carries last,
// and overflow when a load was dropped; the run then empties both stores.
// Requests are taken only while no run is in progress, but a load may be
// taken while a result still sits in the output register.
// Every pair scans all n new points through a four-stage distance pipeline
// (one new point read per cycle from the new point RAM) and then drains it.
// A stalled receiver holds the output register and the run waits on it.
// Reset empties both stores.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_point_matcher import tpm_pkg::*; #(
  parameter int MAX_TOUCH  = MAX_TOUCH_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IDX_W     = (MAX_TOUCH > 1) ? $clog2(MAX_TOUCH) : 1
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  tpm_req_if.sink    req_i,
  tpm_rsp_if.source  rsp_o
);

  tpm_cmd_t         cmd;
  tpm_sts_t         sts;
  logic [IDX_W-1:0] prev_addr;
  logic [IDX_W-1:0] new_addr;
  logic [IDX_W-1:0] best_idx;

  // The controller owns the fill counts, the used mask and the run sequence.
  tpm_ctrl #(.MAX_TOUCH(MAX_TOUCH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.operation),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .best_idx_i  (best_idx),
    .cmd_o       (cmd),
    .prev_addr_o (prev_addr),
    .new_addr_o  (new_addr)
  );

  // The datapath holds both point stores, the distance pipeline and the
  // output register that decouples a stalled receiver.
  tpm_dp #(.MAX_TOUCH(MAX_TOUCH), .COORD_BITS(COORD_BITS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .prev_addr_i    (prev_addr),
    .new_addr_i     (new_addr),
    .point_x_i      (req_i.point_x),
    .point_y_i      (req_i.point_y),
    .sts_o          (sts),
    .best_idx_o     (best_idx),
    .rsp_valid_o    (rsp_o.valid),
    .rsp_ready_i    (rsp_o.ready),
    .rsp_kind_o     (rsp_o.kind),
    .rsp_from_x_o   (rsp_o.from_x),
    .rsp_from_y_o   (rsp_o.from_y),
    .rsp_to_x_o     (rsp_o.to_x),
    .rsp_to_y_o     (rsp_o.to_y),
    .rsp_overflow_o (rsp_o.overflow),
    .rsp_last_o     (rsp_o.last)
  );

  // A result is never written over one that the receiver has not taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten while full");

  // Store writes only follow an accepted request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.prev_we || cmd.new_we) |-> (req_i.valid && req_i.ready))
    else $error("point store written without a request");

  // A movement is emitted only after the distance pipeline has drained.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_load && (cmd.out_kind == KIND_MOVE)) |-> !sts.busy)
    else $error("movement emitted before best match settled");

endmodule

`default_nettype wire

// ===== src/tpm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/tpm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Touch point matcher controller
// Counts loads, sequences the pairing scan and the result emission.
// ----------------------------------------------------------------------------
`default_nettype none

module tpm_ctrl import tpm_pkg::*; #(
  parameter int MAX_TOUCH = MAX_TOUCH_DEF,
  localparam int CNT_W    = $clog2(MAX_TOUCH + 1),
  localparam int IDX_W    = (MAX_TOUCH > 1) ? $clog2(MAX_TOUCH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  input  wire logic [1:0]       req_op_i,
  output logic                  req_ready_o,
  input  wire tpm_sts_t         sts_i,
  input  wire logic [IDX_W-1:0] best_idx_i,
  output tpm_cmd_t              cmd_o,
  output logic      [IDX_W-1:0] prev_addr_o,
  output logic      [IDX_W-1:0] new_addr_o
);

  tpm_state_e             state_q, state_d;
  logic [CNT_W-1:0]       prev_cnt_q, prev_cnt_d;
  logic [CNT_W-1:0]       new_cnt_q, new_cnt_d;
  logic [CNT_W-1:0]       i_q, i_d;
  logic [CNT_W-1:0]       j_q, j_d;
  logic [CNT_W-1:0]       emit_q, emit_d;
  logic [MAX_TOUCH-1:0]   used_q, used_d;
  logic                   dropped_q, dropped_d;

  tpm_op_e          op;
  logic             accept;
  logic             prev_full, new_full;
  logic             more_pairs, last_issue, j_end, i_end;
  logic [CNT_W-1:0] total;
  logic             last_item;
  logic [IDX_W-1:0] i_idx, j_idx;

  assign op          = tpm_op_e'(req_op_i);
  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign prev_full   = (prev_cnt_q == CNT_W'(MAX_TOUCH));
  assign new_full    = (new_cnt_q == CNT_W'(MAX_TOUCH));
  assign more_pairs  = (i_q < prev_cnt_q) && (i_q < new_cnt_q);
  assign last_issue  = ((j_q + CNT_W'(1)) == new_cnt_q);
  assign j_end       = (j_q == new_cnt_q);
  assign i_end       = (i_q == prev_cnt_q);
  assign i_idx       = i_q[IDX_W-1:0];
  assign j_idx       = j_q[IDX_W-1:0];

  // A run gives max(prev, new) results whenever either store holds a point.
  assign total     = (prev_cnt_q > new_cnt_q) ? prev_cnt_q : new_cnt_q;
  assign last_item = ((emit_q + CNT_W'(1)) == total);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (op == OP_MATCH)) begin
          if ((prev_cnt_q == '0) && (new_cnt_q == '0)) begin
            state_d = ST_NONE;
          end else begin
            state_d = ST_PAIR;
          end
        end
      end
      ST_PAIR:  state_d = more_pairs ? ST_LOADP : ST_NSCAN;
      ST_LOADP: state_d = ST_ISSUE;
      ST_ISSUE: state_d = last_issue ? ST_DRAIN : ST_ISSUE;
      ST_DRAIN: state_d = sts_i.busy ? ST_DRAIN : ST_MOVE;
      ST_MOVE:  state_d = sts_i.out_free ? ST_PAIR : ST_MOVE;
      ST_NSCAN: begin
        if (j_end) begin
          state_d = ST_ESCAN;
        end else if (!used_q[j_idx]) begin
          state_d = ST_NEW;
        end
      end
      ST_NEW:   state_d = sts_i.out_free ? ST_NSCAN : ST_NEW;
      ST_ESCAN: state_d = i_end ? ST_DONE : ST_ENDED;
      ST_ENDED: state_d = sts_i.out_free ? ST_ESCAN : ST_ENDED;
      ST_NONE:  state_d = sts_i.out_free ? ST_DONE : ST_NONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.out_kind = KIND_NONE;
    prev_addr_o = i_idx;
    new_addr_o  = j_idx;
    case (state_q)
      ST_IDLE: begin
        prev_addr_o   = prev_cnt_q[IDX_W-1:0];
        new_addr_o    = new_cnt_q[IDX_W-1:0];
        cmd_o.prev_we = accept && (op == OP_LOAD_PREV) && !prev_full;
        cmd_o.new_we  = accept && (op == OP_LOAD_NEW) && !new_full;
      end
      ST_PAIR: begin
        cmd_o.prev_re = more_pairs;
      end
      ST_LOADP: begin
        cmd_o.latch_prev = 1'b1;
        cmd_o.clr_best   = 1'b1;
      end
      ST_ISSUE: begin
        cmd_o.new_re = 1'b1;
        cmd_o.issue  = !used_q[j_idx];
      end
      ST_DRAIN: begin
        new_addr_o   = best_idx_i;
        cmd_o.new_re = !sts_i.busy;
      end
      ST_MOVE: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_kind = KIND_MOVE;
        cmd_o.out_last = last_item;
      end
      ST_NSCAN: begin
        cmd_o.new_re = !j_end && !used_q[j_idx];
      end
      ST_NEW: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_kind = KIND_NEW;
        cmd_o.out_last = last_item;
      end
      ST_ESCAN: begin
        cmd_o.prev_re = !i_end;
      end
      ST_ENDED: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_kind = KIND_ENDED;
        cmd_o.out_last = last_item;
      end
      ST_NONE: begin
        cmd_o.out_load = sts_i.out_free;
        cmd_o.out_kind = KIND_NONE;
        cmd_o.out_last = 1'b1;
      end
      default: begin
        cmd_o.out_load = 1'b0;
      end
    endcase
    cmd_o.out_ovf = cmd_o.out_last && dropped_q;
  end

  always_comb begin
    prev_cnt_d = prev_cnt_q;
    new_cnt_d  = new_cnt_q;
    i_d        = i_q;
    j_d        = j_q;
    emit_d     = emit_q;
    used_d     = used_q;
    dropped_d  = dropped_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_LOAD_PREV: begin
              if (prev_full) begin
                dropped_d = 1'b1;
              end else begin
                prev_cnt_d = prev_cnt_q + CNT_W'(1);
              end
            end
            OP_LOAD_NEW: begin
              if (new_full) begin
                dropped_d = 1'b1;
              end else begin
                new_cnt_d = new_cnt_q + CNT_W'(1);
              end
            end
            OP_MATCH: begin
              i_d    = '0;
              emit_d = '0;
            end
            default: begin
              i_d = i_q;
            end
          endcase
        end
      end
      ST_PAIR:  j_d = '0;
      ST_ISSUE: j_d = j_q + CNT_W'(1);
      ST_MOVE: begin
        if (sts_i.out_free) begin
          used_d[best_idx_i] = 1'b1;
          i_d    = i_q + CNT_W'(1);
          emit_d = emit_q + CNT_W'(1);
        end
      end
      ST_NSCAN: begin
        if (!j_end && used_q[j_idx]) begin
          j_d = j_q + CNT_W'(1);
        end
      end
      ST_NEW: begin
        if (sts_i.out_free) begin
          j_d    = j_q + CNT_W'(1);
          emit_d = emit_q + CNT_W'(1);
        end
      end
      ST_ENDED: begin
        if (sts_i.out_free) begin
          i_d    = i_q + CNT_W'(1);
          emit_d = emit_q + CNT_W'(1);
        end
      end
      ST_DONE: begin
        prev_cnt_d = '0;
        new_cnt_d  = '0;
        used_d     = '0;
        dropped_d  = 1'b0;
      end
      default: begin
        i_d = i_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      prev_cnt_q <= '0;
      new_cnt_q  <= '0;
      i_q        <= '0;
      j_q        <= '0;
      emit_q     <= '0;
      used_q     <= '0;
      dropped_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      prev_cnt_q <= prev_cnt_d;
      new_cnt_q  <= new_cnt_d;
      i_q        <= i_d;
      j_q        <= j_d;
      emit_q     <= emit_d;
      used_q     <= used_d;
      dropped_q  <= dropped_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/tpm_dp.sv =====
// ----------------------------------------------------------------------------
// Touch point matcher datapath
// Point stores, the squared distance pipeline, best tracker and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tpm_dp import tpm_pkg::*; #(
  parameter int MAX_TOUCH  = MAX_TOUCH_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int IDX_W     = (MAX_TOUCH > 1) ? $clog2(MAX_TOUCH) : 1,
  localparam int PT_W      = 2 * COORD_BITS,
  localparam int SQ_W      = 2 * COORD_BITS,
  localparam int D_W       = SQ_W + 1
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire tpm_cmd_t           cmd_i,
  input  wire logic [IDX_W-1:0]   prev_addr_i,
  input  wire logic [IDX_W-1:0]   new_addr_i,
  input  wire logic [FIELD_W-1:0] point_x_i,
  input  wire logic [FIELD_W-1:0] point_y_i,
  output tpm_sts_t                sts_o,
  output logic      [IDX_W-1:0]   best_idx_o,
  output logic                    rsp_valid_o,
  input  wire logic               rsp_ready_i,
  output logic      [1:0]         rsp_kind_o,
  output logic      [FIELD_W-1:0] rsp_from_x_o,
  output logic      [FIELD_W-1:0] rsp_from_y_o,
  output logic      [FIELD_W-1:0] rsp_to_x_o,
  output logic      [FIELD_W-1:0] rsp_to_y_o,
  output logic                    rsp_overflow_o,
  output logic                    rsp_last_o
);

  logic [PT_W-1:0]       wr_point;
  logic [PT_W-1:0]       prev_rd, new_rd;
  logic [COORD_BITS-1:0] prev_rd_x, prev_rd_y, new_rd_x, new_rd_y;

  assign wr_point  = {COORD_BITS'(point_x_i), COORD_BITS'(point_y_i)};
  assign prev_rd_x = prev_rd[PT_W-1:COORD_BITS];
  assign prev_rd_y = prev_rd[COORD_BITS-1:0];
  assign new_rd_x  = new_rd[PT_W-1:COORD_BITS];
  assign new_rd_y  = new_rd[COORD_BITS-1:0];

  tpm_ram #(.WIDTH(PT_W), .DEPTH(MAX_TOUCH)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.prev_we),
    .waddr_i (prev_addr_i),
    .wdata_i (wr_point),
    .re_i    (cmd_i.prev_re),
    .raddr_i (prev_addr_i),
    .rdata_o (prev_rd)
  );

  tpm_ram #(.WIDTH(PT_W), .DEPTH(MAX_TOUCH)) u_new_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.new_we),
    .waddr_i (new_addr_i),
    .wdata_i (wr_point),
    .re_i    (cmd_i.new_re),
    .raddr_i (new_addr_i),
    .rdata_o (new_rd)
  );

  // Previous point under test.
  logic [COORD_BITS-1:0] px_q, py_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_prev) begin
      px_q <= prev_rd_x;
      py_q <= prev_rd_y;
    end
  end

  // Distance pipeline: read, absolute difference, square, sum and compare.
  logic                  s1_v_q, s2_v_q, s3_v_q;
  logic [IDX_W-1:0]      s1_idx_q, s2_idx_q, s3_idx_q;
  logic [COORD_BITS-1:0] dx_d, dy_d, dx_q, dy_q;
  logic [SQ_W-1:0]       sqx_q, sqy_q;
  logic [D_W-1:0]        dist_sum, best_d_q;
  logic [IDX_W-1:0]      best_idx_q;
  logic                  have_q;
  logic                  better;

  assign dx_d     = (new_rd_x >= px_q) ? (new_rd_x - px_q) : (px_q - new_rd_x);
  assign dy_d     = (new_rd_y >= py_q) ? (new_rd_y - py_q) : (py_q - new_rd_y);
  assign dist_sum = D_W'(sqx_q) + D_W'(sqy_q);
  assign better   = s3_v_q && (!have_q || (dist_sum < best_d_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      have_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      if (cmd_i.clr_best) begin
        have_q <= 1'b0;
      end else if (better) begin
        have_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= new_addr_i;
    s2_idx_q <= s1_idx_q;
    s3_idx_q <= s2_idx_q;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    sqx_q    <= SQ_W'(dx_q) * SQ_W'(dx_q);
    sqy_q    <= SQ_W'(dy_q) * SQ_W'(dy_q);
    if (better) begin
      best_d_q   <= dist_sum;
      best_idx_q <= s3_idx_q;
    end
  end

  assign best_idx_o = best_idx_q;

  // Result register.
  logic                  out_v_q;
  tpm_kind_e             out_kind_q;
  logic [COORD_BITS-1:0] fx_q, fy_q, tx_q, ty_q;
  logic [COORD_BITS-1:0] fx_d, fy_d, tx_d, ty_d;
  logic                  ovf_q, last_q;

  always_comb begin
    fx_d = '0;
    fy_d = '0;
    tx_d = '0;
    ty_d = '0;
    case (cmd_i.out_kind)
      KIND_MOVE: begin
        fx_d = px_q;
        fy_d = py_q;
        tx_d = new_rd_x;
        ty_d = new_rd_y;
      end
      KIND_NEW: begin
        tx_d = new_rd_x;
        ty_d = new_rd_y;
      end
      KIND_ENDED: begin
        fx_d = prev_rd_x;
        fy_d = prev_rd_y;
      end
      default: begin
        fx_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_v_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_kind_q <= cmd_i.out_kind;
      fx_q       <= fx_d;
      fy_q       <= fy_d;
      tx_q       <= tx_d;
      ty_q       <= ty_d;
      ovf_q      <= cmd_i.out_ovf;
      last_q     <= cmd_i.out_last;
    end
  end

  assign sts_o.busy     = s1_v_q || s2_v_q || s3_v_q;
  assign sts_o.out_free = !out_v_q || rsp_ready_i;

  assign rsp_valid_o    = out_v_q;
  assign rsp_kind_o     = out_kind_q;
  assign rsp_from_x_o   = FIELD_W'(fx_q);
  assign rsp_from_y_o   = FIELD_W'(fy_q);
  assign rsp_to_x_o     = FIELD_W'(tx_q);
  assign rsp_to_y_o     = FIELD_W'(ty_q);
  assign rsp_overflow_o = ovf_q;
  assign rsp_last_o     = last_q;

endmodule

`default_nettype wire
